/* rtl/itoa_pkg.sv */
// Shared constants, opcodes and character helper for the integer to ASCII formatter.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int BIN_W      = 16;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int ITER_W     = 4;

    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_ALPHA = 7'd55;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    localparam logic [3:0] OP_U8_PAD    = 4'd0;
    localparam logic [3:0] OP_U8_PLAIN  = 4'd1;
    localparam logic [3:0] OP_S8_PAD    = 4'd2;
    localparam logic [3:0] OP_S8_PLAIN  = 4'd3;
    localparam logic [3:0] OP_U16_PAD   = 4'd4;
    localparam logic [3:0] OP_U16_PLAIN = 4'd5;
    localparam logic [3:0] OP_S16_PAD   = 4'd6;
    localparam logic [3:0] OP_S16_PLAIN = 4'd7;
    localparam logic [3:0] OP_HEX2      = 4'd8;
    localparam logic [3:0] OP_HEX4      = 4'd9;

    typedef struct packed {
        logic busy;
        logic done;
    } dd_status_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] wide;
        wide = {3'b000, nib};
        return (nib < 4'd10) ? (wide + CHAR_ZERO) : (wide + CHAR_ALPHA);
    endfunction

endpackage

/* rtl/itoa_dabble.sv */
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
`timescale 1ns / 1ps

module itoa_dabble (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [itoa_pkg::BIN_W-1:0]   bin_in,
    output itoa_pkg::dd_status_t         status,
    output logic [itoa_pkg::BCD_W-1:0]   bcd_out
);
    import itoa_pkg::*;

    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BCD_W-1:0]  adj;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                            (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = bin_in;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ITER_W'(BIN_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd_out     = bcd_reg;

endmodule

/* rtl/integer_to_ascii_formatter.sv */
// Top level: format decoder, character sequencer and output register.
`timescale 1ns / 1ps

// Converts a 16-bit value under a 4-bit format opcode into a run of ASCII
// characters. Input beats arrive on the s_ channel; each produces 1 to 6
// output beats on the m_ channel, the final one flagged by m_tlast.
// Decimal formats run the value through a bit-serial BCD converter, one
// value bit per cycle. The sequencer then visits one character slot per
// cycle unless a stall on m_tready holds it, and a suppressed leading zero
// uses its slot without a beat. Hex formats skip the converter.
// s_tready is high only while no conversion is in progress; it rises again
// as soon as the final character is in the output register, even if that
// character has not yet been taken.
// A stall on m_tready holds the output register and stops the sequencer at
// its next character slot; no character is lost or repeated.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// any pending output beat.
module integer_to_ascii_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [15:0] value
    input  logic [3:0]  s_tuser,  // [3:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [6:0] char_code, [7] zero
    output logic        m_tlast
);
    import itoa_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

    localparam logic [2:0] SLOT_SIGN = 3'd0;
    localparam logic [2:0] SLOT_LAST = 3'd5;

    state_t            state_reg, state_next;
    logic [BCD_W-1:0]  digits_reg, digits_next;
    logic [2:0]        idx_reg, idx_next;
    logic [2:0]        first_reg, first_next;
    logic              plain_reg, plain_next;
    logic              started_reg, started_next;
    logic [6:0]        sign_reg, sign_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [6:0]        char_reg, char_next;
    logic              last_reg, last_next;

    logic [3:0]        opcode;
    logic [BIN_W-1:0]  value;
    logic              accept;
    logic              out_free;
    logic              dd_start;
    dd_status_t        dd_status;
    logic [BCD_W-1:0]  dd_bcd;

    logic [BIN_W-1:0]  dec_mag;
    logic [BCD_W-1:0]  dec_hex;
    logic [2:0]        dec_first;
    logic              dec_conv;
    logic              dec_signed;
    logic              dec_neg;
    logic [3:0]        nib;
    logic              skip;

    assign opcode   = s_tuser;
    assign value    = s_tdata;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign dd_start = accept && dec_conv;

    always_comb begin
        dec_mag    = value;
        dec_hex    = '0;
        dec_first  = 3'd1;
        dec_conv   = 1'b1;
        dec_signed = 1'b0;
        dec_neg    = 1'b0;
        unique case (opcode) inside
            OP_U8_PAD, OP_U8_PLAIN: begin
                dec_mag   = {8'h00, value[7:0]};
                dec_first = 3'd3;
            end
            OP_S8_PAD, OP_S8_PLAIN: begin
                dec_signed = 1'b1;
                dec_neg    = value[7];
                dec_mag    = value[7] ? {8'h00, 8'(-value[7:0])} : {8'h00, value[7:0]};
                dec_first  = 3'd3;
            end
            OP_U16_PAD, OP_U16_PLAIN: begin
                dec_mag = value;
            end
            OP_S16_PAD, OP_S16_PLAIN: begin
                dec_signed = 1'b1;
                dec_neg    = value[15];
                dec_mag    = value[15] ? BIN_W'(-value) : value;
            end
            OP_HEX2: begin
                dec_conv  = 1'b0;
                dec_hex   = {12'h000, value[7:0]};
                dec_first = 3'd4;
            end
            OP_HEX4: begin
                dec_conv  = 1'b0;
                dec_hex   = {4'h0, value};
                dec_first = 3'd2;
            end
            default: begin
                dec_conv  = 1'b0;
                dec_hex   = {16'h0000, value[3:0]};
                dec_first = SLOT_LAST;
            end
        endcase
    end

    always_comb begin
        case (idx_reg)
            3'd1:    nib = digits_reg[19:16];
            3'd2:    nib = digits_reg[15:12];
            3'd3:    nib = digits_reg[11:8];
            3'd4:    nib = digits_reg[7:4];
            default: nib = digits_reg[3:0];
        endcase
    end

    assign skip = plain_reg && !started_reg && (nib == 4'd0) && (idx_reg != SLOT_LAST);

    always_comb begin
        state_next    = state_reg;
        digits_next   = digits_reg;
        idx_next      = idx_reg;
        first_next    = first_reg;
        plain_next    = plain_reg;
        started_next  = started_reg;
        sign_next     = sign_reg;
        m_tvalid_next = out_free ? 1'b0 : m_tvalid_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    digits_next  = dec_hex;
                    first_next   = dec_first;
                    idx_next     = dec_signed ? SLOT_SIGN : dec_first;
                    plain_next   = dec_conv && opcode[0];
                    started_next = 1'b0;
                    sign_next    = dec_neg ? CHAR_MINUS : CHAR_PLUS;
                    state_next   = dec_conv ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV: begin
                if (dd_status.done) begin
                    digits_next = dd_bcd;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (idx_reg != SLOT_SIGN && skip) begin
                    idx_next = idx_reg + 3'd1;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (idx_reg == SLOT_SIGN) begin
                        char_next = sign_reg;
                        last_next = 1'b0;
                        idx_next  = first_reg;
                    end else begin
                        char_next    = hex_char(nib);
                        last_next    = (idx_reg == SLOT_LAST);
                        started_next = 1'b1;
                        if (idx_reg == SLOT_LAST) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        digits_reg  <= digits_next;
        idx_reg     <= idx_next;
        first_reg   <= first_next;
        plain_reg   <= plain_next;
        started_reg <= started_next;
        sign_reg    <= sign_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    itoa_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dd_start),
        .bin_in  (dec_mag),
        .status  (dd_status),
        .bcd_out (dd_bcd)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

/* rtl/itoa_checker.sv */
// Port-level checks for the integer to ASCII formatter, bound to the top level.
`timescale 1ns / 1ps

module itoa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // hold a stalled beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

    // drop ready after taking a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while conversion in progress");

    // only the final character of a run may wait while idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("idle with a non-final character pending");

    // no character in the first cycle after an input beat taken with no beat pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("character appeared without conversion time");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
